### rtl/bitmap_block_allocator_top_macros.svh
// Assertion macros for the bitmap block allocator.
// Included by bitmap_block_allocator_top.sv; expects clk_i and rst_ni in scope.
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BBA_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define BBA_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bba_pkg.sv
// Shared constants for the bitmap block allocator.
// No dependencies; imported by bitmap_block_allocator_top.
`default_nettype none

package bba_pkg;

  // Default block count and the span that the 10-bit index can address
  localparam int unsigned BBA_BLOCKS_DEF = 1024;
  localparam int unsigned INDEX_SPAN     = 1024;
  localparam int unsigned INDEX_W        = 10;
  localparam int unsigned WORD_BITS      = 32;
  localparam int unsigned BIT_W          = 5;

  // Operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

endpackage

`default_nettype wire

### rtl/bitmap_block_allocator_top.sv
// Bitmap first-fit block allocator: used/free bitmap in a one-port-read word memory.
// Depends on bba_pkg and bitmap_block_allocator_top_macros.svh.
//
//   channel | direction | signals
//   --------+-----------+--------------------------------------------------------
//   in      | input     | in_valid_i, in_ready_o, operation_i, block_index_i
//   out     | output    | out_valid_o, out_ready_i, allocated_index_o, found_o,
//           |           | is_free_o
//
// One request at a time. Allocate reads one 32-bit bitmap word per cycle from the
// memory, from word 0 up, until a word holds a free block or the last word is read.
// Mark, free and query read their word once; mark and free write it back. An index
// out of range skips the memory. A finished beat waits in the output register while the
// next request is taken. Reset clears the per-word valid bits at once, no sweep.
`default_nettype none

module bitmap_block_allocator_top
  import bba_pkg::*;
#(
  parameter int unsigned BLOCKS = BBA_BLOCKS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [INDEX_W-1:0] block_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [INDEX_W-1:0]      allocated_index_o,
  output logic                    found_o,
  output logic                    is_free_o
);

  // Only blocks below the index span are reachable
  localparam int unsigned LIVE  = (BLOCKS < INDEX_SPAN) ? BLOCKS : INDEX_SPAN;
  localparam int unsigned WORDS = (LIVE + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned TAIL  = LIVE % WORD_BITS;
  localparam logic [WORD_BITS-1:0] TAIL_MASK =
    (TAIL == 0) ? '0 : ~((WORD_BITS'(1) << TAIL) - WORD_BITS'(1));
  localparam logic [WAW-1:0]     LAST_W = WAW'(WORDS - 1);
  localparam logic [INDEX_W:0]   LIVE_W = (INDEX_W + 1)'(LIVE);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [1:0]          op_q, op_d;
  logic [INDEX_W-1:0]  idx_q, idx_d;
  logic [WAW-1:0]      ptr_q, ptr_d;
  logic [INDEX_W-1:0]  res_index_q, res_index_d;
  logic                res_found_q, res_found_d;
  logic                res_free_q, res_free_d;
  logic                out_valid_q;
  logic [INDEX_W-1:0]  out_index_q;
  logic                out_found_q, out_free_q;

  // Bitmap memory and its per-word valid bits
  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     vld_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rvld_q;
  logic                 rd_en;
  logic [WAW-1:0]       rd_addr;
  logic                 wr_en;
  logic [WAW-1:0]       wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic                 in_fire;
  logic                 in_range;
  logic                 out_load;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] scan_word;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] first_free;
  logic [BIT_W-1:0]     free_bit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_range   = ({1'b0, block_index_i} < LIVE_W);
  assign out_load   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // Unwritten words read as all free; bits past the last block count as used
  assign word       = rvld_q ? rdata_q : '0;
  assign scan_word  = word | ((ptr_q == LAST_W) ? TAIL_MASK : '0);
  assign free_bits  = ~scan_word;
  assign first_free = free_bits & (~free_bits + WORD_BITS'(1));

  // Encode the isolated lowest free bit
  always_comb begin
    free_bit = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (first_free[i]) begin
        free_bit = free_bit | BIT_W'(i);
      end
    end
  end

  // Sequencer: address the memory, modify the word, build the result
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    res_index_d = res_index_q;
    res_found_d = res_found_q;
    res_free_d  = res_free_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = word;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d        = operation_i;
          idx_d       = block_index_i;
          ptr_d       = '0;
          res_index_d = '0;
          res_found_d = 1'b0;
          res_free_d  = 1'b0;
          if (operation_i == OP_ALLOC) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = ST_SCAN;
          end else if (in_range) begin
            rd_en   = 1'b1;
            rd_addr = block_index_i[BIT_W +: WAW];
            state_d = ST_RD;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_RD: begin
        wr_addr = idx_q[BIT_W +: WAW];
        case (op_q)
          OP_MARK: begin
            wr_en   = 1'b1;
            wr_data = word | (WORD_BITS'(1) << idx_q[BIT_W-1:0]);
          end
          OP_FREE: begin
            wr_en   = 1'b1;
            wr_data = word & ~(WORD_BITS'(1) << idx_q[BIT_W-1:0]);
          end
          default: begin
            res_free_d = ~word[idx_q[BIT_W-1:0]];
          end
        endcase
        state_d = ST_FIN;
      end
      ST_SCAN: begin
        if (free_bits != '0) begin
          wr_en       = 1'b1;
          wr_addr     = ptr_q;
          wr_data     = word | first_free;
          res_index_d = INDEX_W'({ptr_q, free_bit});
          res_found_d = 1'b1;
          state_d     = ST_FIN;
        end else if (ptr_q == LAST_W) begin
          state_d = ST_FIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_q + WAW'(1);
          ptr_d   = ptr_q + WAW'(1);
        end
      end
      default: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // Bitmap memory: registered read, single write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Valid bits and the registered valid of the read word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= vld_q[rd_addr];
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    idx_q       <= idx_d;
    ptr_q       <= ptr_d;
    res_index_q <= res_index_d;
    res_found_q <= res_found_d;
    res_free_q  <= res_free_d;
    if (out_load) begin
      out_index_q <= res_index_q;
      out_found_q <= res_found_q;
      out_free_q  <= res_free_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign allocated_index_o = out_index_q;
  assign found_o           = out_found_q;
  assign is_free_o         = out_free_q;

  // Checks
`include "bitmap_block_allocator_top_macros.svh"

  `BBA_ASSERT_NEXT(a_one_at_a_time, in_fire, !in_ready_o, "request taken while busy")
  `BBA_ASSERT_NOW(a_found_not_free, out_valid_o && found_o, !is_free_o, "found and is_free")
  `BBA_ASSERT_NOW(a_none_zero, out_valid_o && !found_o, allocated_index_o == '0, "index not zero")
  `BBA_ASSERT_NOW(a_scan_bound, state_q == ST_SCAN, ptr_q <= LAST_W, "scan past last word")

endmodule

`default_nettype wire
